FILE: rtl/core/stm_pkg.sv
package stm_pkg;

  // field widths
  localparam int CodeW  = 12;
  localparam int GainW  = 16;
  localparam int RowW   = 7;
  localparam int OutRowW = 8;
  localparam int CountW = 12;

  // register indexes on the configuration port
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_GAIN      = 2'd1;
  localparam logic [1:0] REG_TOP       = 2'd2;
  localparam logic [1:0] REG_HEIGHT    = 2'd3;

  // register reset values
  localparam logic [CodeW-1:0] THRESHOLD_RST = 12'd819;
  localparam logic [GainW-1:0] GAIN_RST      = 16'd1040;
  localparam logic [RowW-1:0]  TOP_RST       = 7'd20;
  localparam logic [RowW-1:0]  HEIGHT_RST    = 7'd65;

  // crossing counter saturates here
  localparam logic [CountW-1:0] COUNT_MAX = 12'hFFF;

  // one result item
  typedef struct packed {
    logic [CountW-1:0]  crossing_total;
    logic [CodeW-1:0]   peak_to_peak;
    logic [CodeW-1:0]   frame_max;
    logic [CodeW-1:0]   frame_min;
    logic [OutRowW-1:0] trace_row;
  } stm_result_t;

endpackage

FILE: rtl/core/scope_trace_measure.sv
// Maps a stream of ADC codes to display rows and measures each frame of
// FRAME_SAMPLES samples: running minimum, running maximum, peak-to-peak and
// the number of transitions across crossing_threshold (high means strictly
// above it). The row is (trace_top + trace_height) - ((code * vertical_gain)
// >> 16), clamped to the trace area; vertical_gain is Q16 rows per code.
// The first sample of a frame restarts all measurements and the last one is
// marked with m_tlast, at which point the summary fields hold the frame
// figures. The row multiply and the min, max and crossing updates run in one
// pass into the output register, so a new sample is taken every cycle while
// the downstream side keeps up; the result appears in the cycle after its
// sample is taken. Codes are masked to SAMPLE_BITS bits. Registers sit at byte
// addresses 0 (threshold), 4 (gain), 8 (top) and 12 (height); the user must
// write them only while the stream is idle. The block does not enforce this.
module scope_trace_measure #(
  parameter int FRAME_SAMPLES = 128,
  parameter int SAMPLE_BITS   = 12
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // sample input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] sample_code
  // result output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [7:0] trace_row, [19:8] frame_min, [31:20] frame_max,
                                 // [43:32] peak_to_peak, [55:44] crossing_total
  output logic        m_tlast    // frame_end
);
  import stm_pkg::*;

  localparam int POS_W = (FRAME_SAMPLES > 2) ? $clog2(FRAME_SAMPLES) : 1;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_SAMPLES - 1);
  localparam int MASK_W = (SAMPLE_BITS < CodeW) ? SAMPLE_BITS : CodeW;
  localparam logic [CodeW-1:0] CODE_MASK = CodeW'((1 << MASK_W) - 1);

  // configuration registers
  logic [CodeW-1:0] crossing_threshold;
  logic [GainW-1:0] vertical_gain;
  logic [RowW-1:0]  trace_top;
  logic [RowW-1:0]  trace_height;

  // frame state
  logic [POS_W-1:0]  sample_position;
  logic [CodeW-1:0]  running_min;
  logic [CodeW-1:0]  running_max;
  logic              was_above;
  logic [CountW-1:0] crossing_count;

  // output register
  stm_result_t result;
  logic        result_last;
  logic        result_valid;

  logic              cfg_write;
  logic [1:0]        cfg_index;
  logic              in_fire;
  logic [CodeW-1:0]  code;
  logic              above;
  logic              first;
  logic              last;
  logic [CodeW-1:0]  running_min_next;
  logic [CodeW-1:0]  running_max_next;
  logic              was_above_next;
  logic [CountW-1:0] crossing_count_next;
  logic [CodeW+GainW-1:0] product;
  logic [CodeW-1:0]  drop;
  logic [OutRowW-1:0] bottom;
  logic [OutRowW-1:0] row;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      crossing_threshold <= THRESHOLD_RST;
      vertical_gain      <= GAIN_RST;
      trace_top          <= TOP_RST;
      trace_height       <= HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_THRESHOLD: crossing_threshold <= pwdata[CodeW-1:0];
        REG_GAIN:      vertical_gain      <= pwdata[GainW-1:0];
        REG_TOP:       trace_top          <= pwdata[RowW-1:0];
        REG_HEIGHT:    trace_height       <= pwdata[RowW-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_index)
      REG_THRESHOLD: prdata = {{(32-CodeW){1'b0}}, crossing_threshold};
      REG_GAIN:      prdata = {{(32-GainW){1'b0}}, vertical_gain};
      REG_TOP:       prdata = {{(32-RowW){1'b0}}, trace_top};
      REG_HEIGHT:    prdata = {{(32-RowW){1'b0}}, trace_height};
      default:       prdata = '0;
    endcase
  end

  // stream handshake: take a sample whenever the output register frees up
  assign s_tready = !result_valid || m_tready;
  assign in_fire  = s_tvalid && s_tready;

  // frame measurements
  assign code  = s_tdata[CodeW-1:0] & CODE_MASK;
  assign above = code > crossing_threshold;
  assign first = (sample_position == '0);
  assign last  = (sample_position == LAST_POS);

  always_comb begin
    if (first) begin
      running_min_next    = code;
      running_max_next    = code;
      was_above_next      = above;
      crossing_count_next = '0;
    end else begin
      running_min_next    = (code < running_min) ? code : running_min;
      running_max_next    = (code > running_max) ? code : running_max;
      was_above_next      = above;
      crossing_count_next = crossing_count;
      if (above != was_above && crossing_count != COUNT_MAX) begin
        crossing_count_next = crossing_count + 1'b1;
      end
    end
  end

  // row mapping with clamp to the top of the trace area
  assign product = code * vertical_gain;
  assign drop    = product[CodeW+GainW-1:GainW];
  assign bottom  = {1'b0, trace_top} + {1'b0, trace_height};

  always_comb begin
    if (drop > {{(CodeW-RowW){1'b0}}, trace_height}) begin
      row = {1'b0, trace_top};
    end else begin
      row = bottom - drop[OutRowW-1:0];
    end
  end

  // state update on each sample transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_position <= '0;
      running_min     <= '0;
      running_max     <= '0;
      was_above       <= 1'b0;
      crossing_count  <= '0;
    end else if (in_fire) begin
      sample_position <= last ? '0 : sample_position + 1'b1;
      running_min     <= running_min_next;
      running_max     <= running_max_next;
      was_above       <= was_above_next;
      crossing_count  <= crossing_count_next;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (in_fire) begin
      result_valid <= 1'b1;
    end else if (m_tready) begin
      result_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      result.trace_row      <= row;
      result.frame_min      <= running_min_next;
      result.frame_max      <= running_max_next;
      result.peak_to_peak   <= running_max_next - running_min_next;
      result.crossing_total <= crossing_count_next;
      result_last           <= last;
    end
  end

  assign m_tvalid = result_valid;
  assign m_tdata  = result;
  assign m_tlast  = result_last;

`ifndef SYNTHESIS
  // the last sample of a frame wraps the position
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && last) |=> (sample_position == '0))
    else $error("frame position did not wrap after last sample");

  // the first sample of a frame restarts the crossing count
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && first) |=> (crossing_count == '0))
    else $error("crossing count not restarted at frame start");

  // a delivered result never has its minimum above its maximum
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.frame_min <= result.frame_max))
    else $error("frame minimum above frame maximum");

  // a stalled result stays valid and keeps its last flag until it is taken
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !m_tready) |=> (result_valid && $stable(result_last)))
    else $error("held result changed while stalled");
`endif

endmodule
